@@ hdl/fap_weighted_vertex_deform_assert.svh @@
// Assertion macros for the weighted vertex deformer.
// Used by the top level only; no other dependencies.
`ifndef FAP_WEIGHTED_VERTEX_DEFORM_ASSERT_SVH
`define FAP_WEIGHTED_VERTEX_DEFORM_ASSERT_SVH
// implication checked every clock outside reset
`define FAP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fap assertion failed");
// next-cycle implication checked every clock outside reset
`define FAP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fap assertion failed");
`endif

@@ hdl/fap_pkg.sv @@
// Shared types, constants and direction table for the vertex deformer.
// No dependencies.
package fap_pkg;
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_SETP   = 2'd1,
        OP_DEFORM = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_SAT   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CLEAR,
        BK_READ,
        BK_SCAN,
        BK_MUL,
        BK_ACC,
        BK_DONE
    } bk_state_t;

    localparam logic [16:0] WEIGHT_ONE = 17'd65536;
    localparam int DIR_ENTRIES = 68;

    typedef struct packed {
        op_t         op;
        logic        vtx_bad;
        logic        pidx_bad;
        logic [15:0] vtx;
        logic [6:0]  pidx;
        logic [16:0] weight;
        logic [31:0] pval;
        logic [31:0] bx;
        logic [31:0] by;
        logic [31:0] bz;
    } cmd_t;

    // direction component times two, packed as 3 bits per axis (x,y,z)
    function automatic logic [8:0] dir2(input logic [6:0] idx);
        logic [8:0] d;
        logic [2:0] p, m, h, z;
        p = 3'sd2; m = -3'sd2; h = 3'sd1; z = 3'sd0;
        case (idx)
            7'd2, 7'd3, 7'd7, 7'd8, 7'd24, 7'd25, 7'd47, 7'd50, 7'd54, 7'd55:
                d = {z, m, z};
            7'd4, 7'd9, 7'd10, 7'd11, 7'd12, 7'd17, 7'd20, 7'd21, 7'd30, 7'd31,
            7'd32, 7'd33, 7'd34, 7'd35, 7'd40, 7'd41, 7'd43, 7'd45, 7'd51, 7'd56,
            7'd57, 7'd58, 7'd59, 7'd62, 7'd64, 7'd65:
                d = {z, p, z};
            7'd5, 7'd22, 7'd23, 7'd37, 7'd38, 7'd48, 7'd52, 7'd60, 7'd66:
                d = {p, z, z};
            7'd6, 7'd14, 7'd36, 7'd39, 7'd42, 7'd49, 7'd53, 7'd61, 7'd63, 7'd67:
                d = {m, z, z};
            7'd13, 7'd15, 7'd16, 7'd26, 7'd27, 7'd44:
                d = {z, z, p};
            7'd18, 7'd19:
                d = {z, m, h};
            7'd28, 7'd29:
                d = {p, p, p};
            7'd46:
                d = {z, p, p};
            default:
                d = {z, z, z};
        endcase
        return d;
    endfunction
endpackage

@@ hdl/fap_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module fap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hdl/fap_front.sv @@
// Front end: accepts items, checks ranges, saturates weights, queues commands.
// Depends on fap_pkg.
module fap_front #(
    parameter int MAX_VERTICES = 4096,
    parameter int PARAM_COUNT  = 68
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic [1:0]   operation,
    input  logic [11:0]  vertex_index,
    input  logic [6:0]   param_index,
    input  logic [16:0]  weight,
    input  logic [31:0]  param_value,
    input  logic [31:0]  base_x,
    input  logic [31:0]  base_y,
    input  logic [31:0]  base_z,
    output logic         cmd_valid,
    input  logic         cmd_take,
    output fap_pkg::cmd_t cmd
);
    import fap_pkg::*;

    cmd_t       q_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       c;
    logic       acc;

    // classify the incoming word
    always_comb
    begin
        c          = '0;
        c.op       = op_t'(operation);
        c.vtx      = 16'(vertex_index);
        c.vtx_bad  = 32'(vertex_index) >= 32'(MAX_VERTICES);
        c.pidx     = param_index;
        c.pidx_bad = 32'(param_index) >= 32'(PARAM_COUNT);
        c.weight   = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
        c.pval     = param_value;
        c.bx       = base_x;
        c.by       = base_y;
        c.bz       = base_z;
    end

    assign full      = cnt_reg == 2'd2;
    assign acc       = push && !full;
    assign cmd_valid = cnt_reg != 2'd0;
    assign cmd       = q_reg[rp_reg];

    // advance queue pointers
    always_comb
    begin
        wp_next  = acc ? !wp_reg : wp_reg;
        rp_next  = (cmd_take && cmd_valid) ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(acc) - 2'(cmd_take && cmd_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // hold queued commands
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            q_reg[wp_reg] <= c;
        end
    end
endmodule

@@ hdl/fap_back.sv @@
// Back end: slot memory, parameter memory, shared multiplier, result queue.
// Depends on fap_pkg and fap_ram.
module fap_back #(
    parameter int MAX_VERTICES     = 4096,
    parameter int SLOTS_PER_VERTEX = 4,
    parameter int PARAM_COUNT      = 68
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_take,
    input  fap_pkg::cmd_t cmd,
    output logic          empty,
    input  logic          pop,
    output logic [31:0]   out_x,
    output logic [31:0]   out_y,
    output logic [31:0]   out_z,
    output logic [1:0]    status,
    output logic          busy
);
    import fap_pkg::*;

    localparam int SLOTS = MAX_VERTICES * SLOTS_PER_VERTEX;
    localparam int SAW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SW    = (SLOTS_PER_VERTEX > 1) ? $clog2(SLOTS_PER_VERTEX) : 1;
    localparam int PW    = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
    localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    bk_state_t   st_reg, st_next;
    cmd_t        cur_reg, cur_next;
    logic [SW:0] s_reg, s_next;
    logic [SAW:0] clr_reg, clr_next;
    logic        cleared_reg, cleared_next;
    logic [31:0] acc_reg [3];
    logic [31:0] acc_next [3];
    logic        sat_reg, sat_next;
    logic [1:0]  stat_reg, stat_next;
    logic [49:0] vw_reg;
    logic [6:0]  idx_reg;
    logic [16:0] rd_w_hold;

    // slot memory: {weight, index}
    logic         sm_we;
    logic [SAW-1:0] sm_waddr, sm_raddr;
    logic [23:0]  sm_wdata, sm_rdata;
    logic         pm_we;
    logic [PW-1:0] pm_waddr, pm_raddr;
    logic [31:0]  pm_wdata;
    logic [31:0]  pm_rdata;

    fap_ram #(.WIDTH(24), .DEPTH(SLOTS)) u_slot (
        .clk(clk), .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata),
        .raddr(sm_raddr), .rdata(sm_rdata));
    fap_ram #(.WIDTH(32), .DEPTH(PARAM_COUNT)) u_param (
        .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
        .raddr(pm_raddr), .rdata(pm_rdata));

    // result queue, two entries
    logic [97:0] rq_reg [2];
    logic        rw_reg, rr_reg;
    logic [1:0]  rc_reg;
    logic        rq_push;
    logic [97:0] rq_data;

    assign empty = rc_reg == 2'd0;
    assign {out_x, out_y, out_z, status} = rq_reg[rr_reg];

    logic [SAW-1:0] slot_addr;
    assign slot_addr = SAW'(cur_reg.vtx[VW-1:0]) * SAW'(SLOTS_PER_VERTEX)
                       + SAW'(s_reg[SW-1:0]);

    logic [6:0]  rd_idx;
    logic [16:0] rd_w;
    assign rd_idx = sm_rdata[6:0];
    assign rd_w   = sm_rdata[23:7];

    logic [8:0] d;
    assign d = dir2(idx_reg);

    // scaled and saturated accumulate of one axis
    function automatic logic [32:0] axis_add(input logic [31:0] a, input logic [49:0] vw,
                                             input logic [2:0] d2);
        logic signed [52:0] p;
        logic signed [52:0] t;
        logic signed [52:0] s;
        logic [32:0] r;
        p = $signed(vw) * $signed(d2);
        t = (p + 53'sd65536) >>> 17;
        s = $signed({{21{a[31]}}, a}) + t;
        if (s > 53'sd2147483647)
            r = {1'b1, 32'h7FFFFFFF};
        else if (s < -53'sd2147483648)
            r = {1'b1, 32'h80000000};
        else
            r = {1'b0, s[31:0]};
        return r;
    endfunction

    logic [32:0] ax, ay, az;
    assign ax = axis_add(acc_reg[0], vw_reg, d[8:6]);
    assign ay = axis_add(acc_reg[1], vw_reg, d[5:3]);
    assign az = axis_add(acc_reg[2], vw_reg, d[2:0]);

    // sequencer next state
    always_comb
    begin
        st_next      = st_reg;
        cur_next     = cur_reg;
        s_next       = s_reg;
        clr_next     = clr_reg;
        cleared_next = cleared_reg;
        acc_next     = acc_reg;
        sat_next     = sat_reg;
        stat_next    = stat_reg;
        cmd_take     = 1'b0;
        sm_we        = 1'b0;
        sm_waddr     = slot_addr;
        sm_wdata     = {cur_reg.weight, cur_reg.pidx};
        sm_raddr     = slot_addr;
        pm_we        = 1'b0;
        pm_waddr     = cur_reg.pidx[PW-1:0];
        pm_wdata     = cur_reg.pval;
        pm_raddr     = rd_idx[PW-1:0];
        rq_push      = 1'b0;
        rq_data      = {acc_reg[0], acc_reg[1], acc_reg[2], stat_reg};
        case (st_reg)
            BK_CLEAR:
            begin
                sm_we    = 1'b1;
                sm_waddr = clr_reg[SAW-1:0];
                sm_wdata = '0;
                // zero the parameter values too on the sweep after reset
                if (cleared_reg && 32'(clr_reg) < 32'(PARAM_COUNT))
                begin
                    pm_we    = 1'b1;
                    pm_waddr = clr_reg[PW-1:0];
                    pm_wdata = '0;
                end
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == 32'(SLOTS - 1))
                    st_next = cleared_reg ? BK_IDLE : BK_DONE;
            end
            BK_IDLE:
            begin
                if (cmd_valid && rc_reg != 2'd2)
                begin
                    cmd_take  = 1'b1;
                    cur_next  = cmd;
                    s_next    = '0;
                    sat_next  = 1'b0;
                    stat_next = ST_OK;
                    acc_next[0] = 32'd0;
                    acc_next[1] = 32'd0;
                    acc_next[2] = 32'd0;
                    case (cmd.op)
                        OP_ADD:
                        begin
                            if (cmd.vtx_bad || cmd.pidx_bad)
                            begin
                                stat_next = ST_RANGE;
                                st_next   = BK_DONE;
                            end
                            else
                                st_next = BK_READ;
                        end
                        OP_SETP:
                        begin
                            stat_next = cmd.pidx_bad ? ST_RANGE : ST_OK;
                            st_next   = BK_DONE;
                        end
                        OP_DEFORM:
                        begin
                            acc_next[0] = cmd.bx;
                            acc_next[1] = cmd.by;
                            acc_next[2] = cmd.bz;
                            if (cmd.vtx_bad)
                            begin
                                stat_next = ST_RANGE;
                                st_next   = BK_DONE;
                            end
                            else
                                st_next = BK_READ;
                        end
                        default:
                        begin
                            clr_next     = '0;
                            cleared_next = 1'b0;
                            st_next      = BK_CLEAR;
                        end
                    endcase
                end
            end
            BK_READ:
                st_next = BK_SCAN;
            BK_SCAN:
            begin
                // slot data valid now; parameter read launched this cycle
                if (cur_reg.op == OP_ADD)
                begin
                    if (rd_w == 17'd0)
                    begin
                        sm_we   = 1'b1;
                        st_next = BK_DONE;
                    end
                    else if (32'(s_reg) == 32'(SLOTS_PER_VERTEX - 1))
                    begin
                        stat_next = ST_FULL;
                        st_next   = BK_DONE;
                    end
                    else
                    begin
                        s_next  = s_reg + 1'b1;
                        st_next = BK_READ;
                    end
                end
                else if (rd_idx == 7'd0)
                begin
                    if (32'(s_reg) == 32'(SLOTS_PER_VERTEX - 1))
                    begin
                        stat_next = sat_reg ? ST_SAT : ST_OK;
                        st_next   = BK_DONE;
                    end
                    else
                    begin
                        s_next  = s_reg + 1'b1;
                        st_next = BK_READ;
                    end
                end
                else
                    st_next = BK_MUL;
            end
            BK_MUL:
                st_next = BK_ACC;
            BK_ACC:
            begin
                acc_next[0] = ax[31:0];
                acc_next[1] = ay[31:0];
                acc_next[2] = az[31:0];
                sat_next    = sat_reg | ax[32] | ay[32] | az[32];
                if (32'(s_reg) == 32'(SLOTS_PER_VERTEX - 1))
                begin
                    stat_next = (sat_reg | ax[32] | ay[32] | az[32]) ? ST_SAT : ST_OK;
                    st_next   = BK_DONE;
                end
                else
                begin
                    s_next  = s_reg + 1'b1;
                    st_next = BK_READ;
                end
            end
            BK_DONE:
            begin
                rq_push = 1'b1;
                if (cur_reg.op != OP_DEFORM)
                    rq_data = {96'd0, stat_reg};
                if (cur_reg.op == OP_SETP && !cur_reg.pidx_bad)
                    pm_we = 1'b1;
                st_next = BK_IDLE;
            end
            default:
                st_next = BK_IDLE;
        endcase
    end

    assign busy = st_reg != BK_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= BK_CLEAR;
            clr_reg     <= '0;
            cleared_reg <= 1'b1;
            rw_reg      <= 1'b0;
            rr_reg      <= 1'b0;
            rc_reg      <= 2'd0;
        end
        else
        begin
            st_reg      <= st_next;
            clr_reg     <= clr_next;
            cleared_reg <= cleared_next;
            if (rq_push)
                rw_reg <= !rw_reg;
            if (pop && !empty)
                rr_reg <= !rr_reg;
            rc_reg <= rc_reg + 2'(rq_push) - 2'(pop && !empty);
        end
    end

    // datapath registers; multiply value by weight, register the product
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        s_reg   <= s_next;
        acc_reg <= acc_next;
        sat_reg <= sat_next;
        stat_reg <= stat_next;
        if (st_reg == BK_SCAN)
            idx_reg <= rd_idx;
        if (st_reg == BK_MUL)
            vw_reg <= 50'($signed(pm_rdata) * $signed({1'b0, rd_w_hold}));
        if (rq_push)
            rq_reg[rw_reg] <= rq_data;
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == BK_SCAN)
            rd_w_hold <= rd_w;
    end
endmodule

@@ hdl/fap_weighted_vertex_deform.sv @@
// Weighted vertex deformer: queue-style input, decoupled back end, queue output.
// Depends on fap_pkg, fap_front, fap_back and the assertion header.
//
// Usage: push an item (operation, vertex_index, param_index, weight,
// param_value, base_x/y/z) while full is low; each item yields one result
// word (out_x/y/z, status), available while empty is low and taken by pop.
// The front end queues up to two classified items; the back end runs one at a
// time through a slot memory and a parameter memory with registered reads and
// one shared value-by-weight multiplier.
// set_param and range errors go straight to their result; add_influence reads
// and checks one slot at a time until it finds an empty one or the last;
// deform reads every slot in turn and multiplies and accumulates each used one;
// all of it goes through the single slot read port. clear_all sweeps the slot
// memory one entry a cycle over all MAX_VERTICES * SLOTS_PER_VERTEX entries.
// After reset the same sweep runs, also zeroing the parameter values, before
// any item is taken; items may still be pushed into the front queue meanwhile.
// If the receiver stalls, two results wait; then the back end holds and the
// front queue fills, raising full.
module fap_weighted_vertex_deform #(
    parameter int MAX_VERTICES     = 4096,
    parameter int SLOTS_PER_VERTEX = 4,
    parameter int PARAM_COUNT      = 68
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  operation,
    input  logic [11:0] vertex_index,
    input  logic [6:0]  param_index,
    input  logic [16:0] weight,
    input  logic [31:0] param_value,
    input  logic [31:0] base_x,
    input  logic [31:0] base_y,
    input  logic [31:0] base_z,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic [31:0] out_z,
    output logic [1:0]  status
);
    import fap_pkg::*;
    `include "fap_weighted_vertex_deform_assert.svh"

    logic  cmd_valid, cmd_take, busy;
    cmd_t  cmd;

    fap_front #(.MAX_VERTICES(MAX_VERTICES), .PARAM_COUNT(PARAM_COUNT)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .operation(operation), .vertex_index(vertex_index),
        .param_index(param_index), .weight(weight), .param_value(param_value),
        .base_x(base_x), .base_y(base_y), .base_z(base_z),
        .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd));

    fap_back #(.MAX_VERTICES(MAX_VERTICES), .SLOTS_PER_VERTEX(SLOTS_PER_VERTEX),
               .PARAM_COUNT(PARAM_COUNT)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
        .cmd(cmd), .empty(empty), .pop(pop), .out_x(out_x), .out_y(out_y),
        .out_z(out_z), .status(status), .busy(busy));

    // a command is taken only when one waits and the back end is idle
    `FAP_ASSERT_IMPL(a_take_valid, cmd_take, cmd_valid && !busy)
    // taking a command makes the back end busy next cycle
    `FAP_ASSERT_NEXT(a_take_busy, cmd_take, busy)
    // a full front queue always offers a command
    `FAP_ASSERT_IMPL(a_full_stall, full, cmd_valid)
endmodule
